// ===== hdl/assert_macros.svh =====
// assertion helpers for the block, empty in synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ACKS_ASSERT_IMP(name, clk, rst_n, a, c) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("same-cycle check failed");
`define ACKS_ASSERT_NXT(name, clk, rst_n, a, c) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("next-cycle check failed");
`else
`define ACKS_ASSERT_IMP(name, clk, rst_n, a, c)
`define ACKS_ASSERT_NXT(name, clk, rst_n, a, c)
`endif
`endif

// ===== hdl/acks_pkg.sv =====
package acks_pkg;

  localparam int unsigned NumWords = 5;
  localparam logic [3:0] MaxRounds = 4'd12;
  localparam logic [3:0] LastRnd = 4'd11;

  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_INIT   = 3'd1,
    OP_ABSORB = 3'd2,
    OP_AD_END = 3'd3,
    OP_DATA   = 3'd4,
    OP_FINAL  = 3'd5
  } acks_op_e;

  typedef enum logic [1:0] {
    CFG_KEY_FIRST   = 2'd0,
    CFG_KEY_SECOND  = 2'd1,
    CFG_INIT_ROUNDS = 2'd2,
    CFG_DATA_ROUNDS = 2'd3
  } acks_cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_DONE
  } acks_state_e;

  typedef logic [NumWords-1:0][63:0] acks_word_arr_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [2:0]  word_index;
    logic [63:0] data_word;
  } acks_in_t;

  typedef struct packed {
    logic [63:0] out_word;
    logic [63:0] tag_first;
    logic [63:0] tag_second;
  } acks_out_t;

  typedef struct packed {
    logic       start;
    logic       round;
    logic       finish;
    logic [3:0] rnd;
  } acks_cmd_t;

  typedef struct packed {
    logic [3:0] first_rnd;
    logic       no_rounds;
  } acks_sts_t;

  function automatic logic [63:0] acks_rotr(input logic [63:0] x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic acks_word_arr_t acks_round(input acks_word_arr_t s, input logic [3:0] r);
    logic [63:0] x0, x1, x2, x3, x4, t0, t1, t2, t3, t4;
    acks_word_arr_t o;
    x0 = s[0];
    x1 = s[1];
    x2 = s[2] ^ {56'd0, ~r, r};
    x3 = s[3];
    x4 = s[4];
    // substitution layer
    x0 = x0 ^ x4;
    x4 = x4 ^ x3;
    x2 = x2 ^ x1;
    t0 = ~x0 & x1;
    t1 = ~x1 & x2;
    t2 = ~x2 & x3;
    t3 = ~x3 & x4;
    t4 = ~x4 & x0;
    x0 = x0 ^ t1;
    x1 = x1 ^ t2;
    x2 = x2 ^ t3;
    x3 = x3 ^ t4;
    x4 = x4 ^ t0;
    x1 = x1 ^ x0;
    x0 = x0 ^ x4;
    x3 = x3 ^ x2;
    x2 = ~x2;
    // linear layer
    o[0] = x0 ^ acks_rotr(x0, 19) ^ acks_rotr(x0, 28);
    o[1] = x1 ^ acks_rotr(x1, 61) ^ acks_rotr(x1, 39);
    o[2] = x2 ^ acks_rotr(x2, 1) ^ acks_rotr(x2, 6);
    o[3] = x3 ^ acks_rotr(x3, 10) ^ acks_rotr(x3, 17);
    o[4] = x4 ^ acks_rotr(x4, 7) ^ acks_rotr(x4, 41);
    return o;
  endfunction

endpackage

// ===== hdl/ascon_like_keystream_cipher_top.sv =====
// channel   dir  handshake               payload
// request   in   in_valid_i/in_ready_o   in_req_i (opcode, word_index, data_word)
// result    out  out_valid_o/out_ready_i out_rsp_o (out_word, tag_first, tag_second)
// config    in   cfg_we_i                cfg_idx_i, cfg_data_i
//
// a request runs through accept, n permutation rounds, write-back
// n is the saturated round count, one round per cycle in the shared round unit
// init and finalize run the init count, blocks the data count, data right after init no rounds
// the result register holds one result; a new request is taken while it waits
// a stalled result holds the write-back step; reset zeroes state and keys, counts 12 and 6
`include "assert_macros.svh"
module ascon_like_keystream_cipher_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  acks_pkg::acks_in_t  in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output acks_pkg::acks_out_t out_rsp_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [63:0]         cfg_data_i
);
  import acks_pkg::*;

  acks_cmd_t cmd;
  acks_sts_t sts;

  acks_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  acks_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_req_i   (in_req_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_rsp_o  (out_rsp_o)
  );

  `ACKS_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `ACKS_ASSERT_NXT(a_finish_fills_out, clk_i, rst_ni, cmd.finish, out_valid_o)
  `ACKS_ASSERT_IMP(a_round_not_ready, clk_i, rst_ni, cmd.round, !in_ready_o && !cmd.finish)
  `ACKS_ASSERT_IMP(a_finish_has_room, clk_i, rst_ni, cmd.finish, !out_valid_o || out_ready_i)

endmodule

// ===== hdl/acks_ctrl.sv =====
module acks_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  acks_pkg::acks_sts_t sts_i,
  output acks_pkg::acks_cmd_t cmd_o
);
  import acks_pkg::*;

  acks_state_e state_q, state_d;
  logic [3:0]  rnd_q, rnd_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rnd_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    rnd_d      = rnd_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          rnd_d       = sts_i.first_rnd;
          state_d     = sts_i.no_rounds ? ST_DONE : ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        cmd_o.rnd   = rnd_q;
        rnd_d       = rnd_q + 4'd1;
        if (rnd_q == LastRnd) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/acks_datapath.sv =====
module acks_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [63:0]         cfg_data_i,
  input  acks_pkg::acks_in_t  in_req_i,
  input  acks_pkg::acks_cmd_t cmd_i,
  output acks_pkg::acks_sts_t sts_o,
  output acks_pkg::acks_out_t out_rsp_o
);
  import acks_pkg::*;

  logic [63:0]    key_first_q, key_second_q;
  logic [3:0]     init_rounds_q, data_rounds_q;
  acks_word_arr_t st_q, st_d;
  logic           pend_q, pend_d;
  logic [2:0]     op_q;
  logic [63:0]    word_q;
  acks_out_t      out_q, out_d;
  logic [3:0]     rnd_sel, rnd_sat;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_first_q   <= 64'd0;
      key_second_q  <= 64'd0;
      init_rounds_q <= MaxRounds;
      data_rounds_q <= 4'd6;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KEY_FIRST:   key_first_q <= cfg_data_i;
        CFG_KEY_SECOND:  key_second_q <= cfg_data_i;
        CFG_INIT_ROUNDS: init_rounds_q <= cfg_data_i[3:0];
        CFG_DATA_ROUNDS: data_rounds_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // round count of the incoming request
  always_comb begin
    case (in_req_i.opcode)
      OP_INIT, OP_FINAL: rnd_sel = init_rounds_q;
      OP_ABSORB:         rnd_sel = data_rounds_q;
      OP_DATA:           rnd_sel = pend_q ? 4'd0 : data_rounds_q;
      default:           rnd_sel = 4'd0;
    endcase
    rnd_sat         = (rnd_sel > MaxRounds) ? MaxRounds : rnd_sel;
    sts_o.first_rnd = MaxRounds - rnd_sat;
    sts_o.no_rounds = (rnd_sat == 4'd0);
  end

  always_comb begin
    st_d   = st_q;
    pend_d = pend_q;
    out_d  = out_q;
    if (cmd_i.start) begin
      case (in_req_i.opcode)
        OP_LOAD: begin
          if (in_req_i.word_index inside {[3'd0:3'd4]}) begin
            st_d[in_req_i.word_index] = in_req_i.data_word;
          end
        end
        OP_ABSORB: st_d[0] = st_q[0] ^ in_req_i.data_word;
        OP_AD_END: st_d[4] = st_q[4] ^ 64'd1;
        OP_FINAL: begin
          st_d[1] = st_q[1] ^ key_first_q;
          st_d[2] = st_q[2] ^ key_second_q;
        end
        default: ;
      endcase
    end else if (cmd_i.round) begin
      st_d = acks_round(st_q, cmd_i.rnd);
    end else if (cmd_i.finish) begin
      out_d.out_word = 64'd0;
      case (op_q)
        OP_INIT: begin
          st_d[3] = st_q[3] ^ key_first_q;
          st_d[4] = st_q[4] ^ key_second_q;
          pend_d  = 1'b1;
        end
        OP_DATA: begin
          out_d.out_word = word_q ^ st_q[0];
          pend_d         = 1'b0;
        end
        OP_FINAL: begin
          st_d[3] = st_q[3] ^ key_first_q;
          st_d[4] = st_q[4] ^ key_second_q;
        end
        default: ;
      endcase
      out_d.tag_first  = st_d[3];
      out_d.tag_second = st_d[4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= '0;
      pend_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q   <= in_req_i.opcode;
      word_q <= in_req_i.data_word;
    end
    out_q <= out_d;
  end

  assign out_rsp_o = out_q;

endmodule

// ===== test/ascon_like_keystream_cipher_top_tb.sv =====
module ascon_like_keystream_cipher_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import acks_pkg::*;

  localparam logic [2:0] OpSpareLow = 3'd6;
  localparam logic [2:0] OpSpareHigh = 3'd7;
  localparam int unsigned StallLimit = 3000;
  localparam int unsigned PhaseItems = 130;
  localparam int unsigned NumPhases = 8;
  localparam logic [7:0][3:0] InitSet = {4'd13, 4'd7, 4'd14, 4'd15, 4'd0, 4'd12, 4'd1, 4'd12};
  localparam logic [7:0][3:0] DataSet = {4'd15, 4'd3, 4'd1, 4'd13, 4'd0, 4'd12, 4'd1, 4'd6};

  class keystream_scoreboard;
    logic [63:0] lane [5];
    bit          fresh_init;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [3:0]  init_cnt;
    logic [3:0]  data_cnt;
    acks_out_t   expected_rsp_q [$];
    int unsigned errors;

    function new();
      foreach (lane[i]) lane[i] = '0;
      fresh_init = 1'b0;
      key_hi = '0;
      key_lo = '0;
      init_cnt = 4'd12;
      data_cnt = 4'd6;
      errors = 0;
    endfunction

    function void set_reg(acks_cfg_e idx, logic [63:0] val);
      case (idx)
        CFG_KEY_FIRST:   key_hi = val;
        CFG_KEY_SECOND:  key_lo = val;
        CFG_INIT_ROUNDS: init_cnt = val[3:0];
        CFG_DATA_ROUNDS: data_cnt = val[3:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] ror(logic [63:0] x, int unsigned n);
      logic [127:0] twice;
      twice = {x, x} >> n;
      return twice[63:0];
    endfunction

    function void one_round(logic [3:0] r);
      logic [63:0] a0, a1, a2, a3, a4;
      logic [63:0] b0, b1, b2, b3, b4;
      a0 = lane[0] ^ lane[4];
      a1 = lane[1];
      a2 = lane[2] ^ {56'd0, ~r, r} ^ lane[1];
      a3 = lane[3];
      a4 = lane[4] ^ lane[3];
      // s-box slices
      b0 = a0 ^ (~a1 & a2);
      b1 = a1 ^ (~a2 & a3);
      b2 = a2 ^ (~a3 & a4);
      b3 = a3 ^ (~a4 & a0);
      b4 = a4 ^ (~a0 & a1);
      b1 = b1 ^ b0;
      b0 = b0 ^ b4;
      b3 = b3 ^ b2;
      b2 = ~b2;
      // linear diffusion
      lane[0] = b0 ^ ror(b0, 19) ^ ror(b0, 28);
      lane[1] = b1 ^ ror(b1, 61) ^ ror(b1, 39);
      lane[2] = b2 ^ ror(b2, 1) ^ ror(b2, 6);
      lane[3] = b3 ^ ror(b3, 10) ^ ror(b3, 17);
      lane[4] = b4 ^ ror(b4, 7) ^ ror(b4, 41);
    endfunction

    function void permute(logic [3:0] cnt);
      logic [3:0] n;
      n = (cnt > 4'd12) ? 4'd12 : cnt;
      for (int i = 0; i < n; i++) one_round(4'(12 - n + i));
    endfunction

    function void note_request(acks_in_t req);
      acks_out_t rsp;
      rsp = '0;
      case (req.opcode)
        OP_LOAD: begin
          if (req.word_index < 3'd5) lane[req.word_index] = req.data_word;
        end
        OP_INIT: begin
          permute(init_cnt);
          lane[3] ^= key_hi;
          lane[4] ^= key_lo;
          fresh_init = 1'b1;
        end
        OP_ABSORB: begin
          lane[0] ^= req.data_word;
          permute(data_cnt);
        end
        OP_AD_END: lane[4] ^= 64'd1;
        OP_DATA: begin
          if (!fresh_init) permute(data_cnt);
          rsp.out_word = req.data_word ^ lane[0];
          fresh_init = 1'b0;
        end
        OP_FINAL: begin
          lane[1] ^= key_hi;
          lane[2] ^= key_lo;
          permute(init_cnt);
          lane[3] ^= key_hi;
          lane[4] ^= key_lo;
        end
        default: ;
      endcase
      rsp.tag_first = lane[3];
      rsp.tag_second = lane[4];
      expected_rsp_q.push_back(rsp);
    endfunction

    function int unsigned pending();
      return expected_rsp_q.size();
    endfunction

    task report(string what);
      $display("%0t mismatch: %s", $time, what);
      errors++;
    endtask

    task check_result(acks_out_t got);
      acks_out_t want;
      if (expected_rsp_q.size() == 0) begin
        report($sformatf("result with no request outstanding: %h", got));
        return;
      end
      want = expected_rsp_q.pop_front();
      if (got.out_word !== want.out_word)
        report($sformatf("out_word %h, expected %h", got.out_word, want.out_word));
      if (got.tag_first !== want.tag_first)
        report($sformatf("tag_first %h, expected %h", got.tag_first, want.tag_first));
      if (got.tag_second !== want.tag_second)
        report($sformatf("tag_second %h, expected %h", got.tag_second, want.tag_second));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  acks_in_t    in_req_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  acks_out_t   out_rsp_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;

  int unsigned idle_in = 20;
  int unsigned idle_out = 20;
  int unsigned quiet_cycles = 0;
  int unsigned items_sent = 0;
  keystream_scoreboard sb;

  ascon_like_keystream_cipher_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= idle_out);

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(out_rsp_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == StallLimit) begin
        $display("ascon_like_keystream_cipher_top verification failed");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic acks_in_t make_req(logic [2:0] op, logic [2:0] idx, logic [63:0] w);
    acks_in_t req;
    req.opcode = op;
    req.word_index = idx;
    req.data_word = w;
    return req;
  endfunction

  task automatic send_req(input acks_in_t req);
    if ($urandom_range(99) < idle_in) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_in);
    end
    in_valid_i <= 1'b1;
    in_req_i <= req;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(req);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input acks_cfg_e idx, input logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  // one message: optional word loads, init, associated data, payload, finalize; or a short burst of random requests
  task automatic run_session();
    int unsigned n_ad;
    int unsigned n_msg;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 4))
        send_req(make_req(3'($urandom_range(7)), 3'($urandom_range(7)), rand64()));
      return;
    end
    if ($urandom_range(1) == 1)
      for (int w = 0; w < 5; w++) send_req(make_req(OP_LOAD, 3'(w), rand64()));
    send_req(make_req(OP_INIT, 3'($urandom_range(7)), rand64()));
    n_ad = $urandom_range(3);
    repeat (n_ad) send_req(make_req(OP_ABSORB, 3'($urandom_range(7)), rand64()));
    if ($urandom_range(9) != 0)
      send_req(make_req(OP_AD_END, 3'($urandom_range(7)), rand64()));
    n_msg = $urandom_range(1, 4);
    repeat (n_msg) send_req(make_req(OP_DATA, 3'($urandom_range(7)), rand64()));
    if ($urandom_range(9) != 0)
      send_req(make_req(OP_FINAL, 3'($urandom_range(7)), rand64()));
  endtask

  initial begin
    int unsigned target;
    logic [63:0] upper;
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, data before init first
    send_req(make_req(OP_DATA, 3'd0, '0));
    send_req(make_req(OP_LOAD, 3'd0, '1));
    for (int w = 1; w < 5; w++) send_req(make_req(OP_LOAD, 3'(w), rand64()));
    for (int w = 5; w < 8; w++) send_req(make_req(OP_LOAD, 3'(w), '1));
    send_req(make_req(OP_INIT, 3'd7, '1));
    send_req(make_req(OP_ABSORB, 3'd0, '1));
    send_req(make_req(OP_ABSORB, 3'd7, '0));
    send_req(make_req(OP_AD_END, 3'd0, rand64()));
    send_req(make_req(OP_DATA, 3'd0, '1));
    send_req(make_req(OP_DATA, 3'd7, '0));
    send_req(make_req(OP_FINAL, 3'd0, rand64()));
    send_req(make_req(OpSpareLow, 3'd0, '1));
    send_req(make_req(OpSpareHigh, 3'd7, rand64()));

    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_drained();
      idle_in = (ph == 2) ? 0 : 20;
      idle_out = (ph == 2) ? 0 : 20;
      upper = (ph % 2 == 1) ? rand64() : '0;
      write_reg(CFG_KEY_FIRST, (ph == 2) ? '1 : (ph == 3) ? '0 : rand64());
      write_reg(CFG_KEY_SECOND, (ph == 2) ? '1 : (ph == 3) ? '0 : rand64());
      write_reg(CFG_INIT_ROUNDS, {upper[63:4], InitSet[ph]});
      write_reg(CFG_DATA_ROUNDS, {upper[63:4], DataSet[ph]});
      cfg_we_i <= 1'b0;
      target = items_sent + PhaseItems;
      while (items_sent < target) begin
        run_session();
        if (ph == 5 && items_sent > target - PhaseItems / 2 && sb.pending() != 0)
          wait_drained();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("ascon_like_keystream_cipher_top verification clean");
    end else begin
      $display("ascon_like_keystream_cipher_top verification failed");
    end
    $finish;
  end

endmodule
